/* rtl/core/mdfs_pkg.sv */
// Shared types, codes and tables for the depth-first maze walker.
package mdfs_pkg;

   localparam int COORD_W = 6;   // reported coordinate width
   localparam int GRID_W  = 7;   // grid size register width
   localparam int PICK_W  = 5;   // order pick width
   localparam int MARK_W  = 8;   // visited-map epoch mark width

   localparam logic KIND_RESTART = 1'b0;

   localparam logic [1:0] EV_CARVE = 2'd0;
   localparam logic [1:0] EV_BACK  = 2'd1;
   localparam logic [1:0] EV_DONE  = 2'd2;
   localparam logic [1:0] EV_IDLE  = 2'd3;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] REG_START_COL   = 2'd2;
   localparam logic [1:0] REG_START_ROW   = 2'd3;

   // Try orders: lexicographic permutations of left, right, up, down.
   // First direction tried sits in bits [7:6]. Picks 24..31 wrap to 0..7.
   localparam logic [7:0] ORDER_LUT [32] = '{
      8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39,
      8'h4B, 8'h4E, 8'h63, 8'h6C, 8'h72, 8'h78,
      8'h87, 8'h8D, 8'h93, 8'h9C, 8'hB1, 8'hB4,
      8'hC6, 8'hC9, 8'hD2, 8'hD8, 8'hE1, 8'hE4,
      8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39, 8'h4B, 8'h4E
   };

   typedef enum logic [3:0] {
      ST_SWEEP  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

endpackage

/* rtl/core/mdfs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module mdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold the last read word while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/maze_dfs_backtracker.sv */
// Depth-first maze walker: visited map and path stack in RAM, one step per beat.
//
// Usage:
//   Configure grid_width, grid_height, start_col and start_row over the APB
//   port (byte addresses 0, 4, 8, 12) while the block is idle.
//   Send a restart beat (req_kind = 0) to clear the map and place the walker;
//   it answers only when the start cell lies outside the grid (event 3).
//   Each step beat (req_kind = 1, req_order_pick) returns one result beat:
//   carve, backtrack, finished, or not started.
// Step sequence:
//   A step in the core issues four visited-map reads through the single
//   read port of the map RAM, then a decide state that pushes or pops the
//   stack and, on a carve, writes the new visited mark.
//   One input beat is buffered while the core works, so the next beat is
//   taken while a result still waits on the output register.
// Reset and clearing:
//   After reset, and after a restart that finds the epoch mark at 255 (it wraps),
//   the map RAM is swept, one entry a cycle, over all 2**(clog2(MAX_COLS) +
//   clog2(MAX_ROWS)) entries (4096 at the defaults); no request beat is taken
//   meanwhile. Restarts otherwise clear the map by bumping the epoch mark.
// Stall:
//   While rsp_stall is high the result holds; the core waits in its decide
//   state and the input buffer fills, which then raises req_stall.
module maze_dfs_backtracker
   import mdfs_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [PICK_W-1:0]   req_order_pick,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_event_res,
   output logic [COORD_W-1:0]  rsp_from_col,
   output logic [COORD_W-1:0]  rsp_from_row,
   output logic [COORD_W-1:0]  rsp_to_col,
   output logic [COORD_W-1:0]  rsp_to_row,
   output logic [1:0]          rsp_direction,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // address bits of one coordinate inside the map
   localparam int CAW = $clog2(MAX_COLS);
   localparam int RAW = $clog2(MAX_ROWS);
   // walker coordinate width: wide enough for the grid and for a reported start
   localparam int PCW = (CAW > COORD_W) ? CAW : COORD_W;
   localparam int PRW = (RAW > COORD_W) ? RAW : COORD_W;
   // compare width: holds coordinate plus one and the grid limits
   localparam int CXW = PCW + 2;
   localparam int RXW = PRW + 2;
   localparam int VAW = CAW + RAW;
   localparam int VDEPTH = 1 << VAW;
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int SAW = $clog2(CELLS);
   localparam int SCW = $clog2(CELLS + 1);
   localparam int SDW = CAW + RAW;

   // ---------------------------------------------------------------- registers
   state_type            state_ff, state_in;
   logic [GRID_W-1:0]    grid_width_ff, grid_width_in;
   logic [GRID_W-1:0]    grid_height_ff, grid_height_in;
   logic [COORD_W-1:0]   start_col_ff, start_col_in;
   logic [COORD_W-1:0]   start_row_ff, start_row_in;

   logic                 hold_valid_ff, hold_valid_in;
   logic                 hold_kind_ff;
   logic [PICK_W-1:0]    hold_pick_ff;
   logic [PICK_W-1:0]    pick_ff, pick_in;

   logic [PCW-1:0]       walker_col_ff, walker_col_in;
   logic [PRW-1:0]       walker_row_ff, walker_row_in;
   logic [SCW-1:0]       count_ff, count_in;
   logic                 active_ff, active_in;
   logic [MARK_W-1:0]    epoch_ff, epoch_in;
   logic [VAW-1:0]       sweep_addr_ff, sweep_addr_in;

   logic [1:0]           rd_idx_ff, rd_idx_in;
   logic [1:0]           rd_dir_ff, rd_dir_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [3:0]           seen_ff, seen_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_event_ff;
   logic [COORD_W-1:0]   rsp_from_col_ff;
   logic [COORD_W-1:0]   rsp_from_row_ff;
   logic [COORD_W-1:0]   rsp_to_col_ff;
   logic [COORD_W-1:0]   rsp_to_row_ff;
   logic [1:0]           rsp_dir_ff;

   // ---------------------------------------------------------------- memories
   logic                 vis_we, vis_re;
   logic [VAW-1:0]       vis_waddr, vis_raddr;
   logic [MARK_W-1:0]    vis_wdata, vis_rdata;
   logic                 stk_we, stk_re;
   logic [SAW-1:0]       stk_waddr, stk_raddr;
   logic [SDW-1:0]       stk_wdata, stk_rdata;

   mdfs_ram #(
      .WIDTH (MARK_W),
      .DEPTH (VDEPTH)
   ) u_visited (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .re    (vis_re),
      .raddr (vis_raddr),
      .rdata (vis_rdata)
   );

   mdfs_ram #(
      .WIDTH (SDW),
      .DEPTH (CELLS)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // ---------------------------------------------------------------- config port
   logic cfg_we;
   assign cfg_we = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      start_col_in   = start_col_ff;
      start_row_in   = start_row_ff;
      if (cfg_we) begin
         case (paddr[3:2])
            REG_GRID_WIDTH:  grid_width_in  = pwdata[GRID_W-1:0];
            REG_GRID_HEIGHT: grid_height_in = pwdata[GRID_W-1:0];
            REG_START_COL:   start_col_in   = pwdata[COORD_W-1:0];
            REG_START_ROW:   start_row_in   = pwdata[COORD_W-1:0];
            default:         grid_width_in  = grid_width_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_GRID_WIDTH:  prdata = 32'(grid_width_ff);
         REG_GRID_HEIGHT: prdata = 32'(grid_height_ff);
         REG_START_COL:   prdata = 32'(start_col_ff);
         REG_START_ROW:   prdata = 32'(start_row_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- neighbours
   // Effective grid: registers clamped to the map size.
   logic [CXW-1:0] eff_w, cx;
   logic [RXW-1:0] eff_h, ry;
   logic           col_in_grid, row_in_grid;
   logic [CXW-1:0] nb_cx   [4];
   logic [RXW-1:0] nb_ry   [4];
   logic [VAW-1:0] nb_addr [4];
   logic [3:0]     nb_ok;

   always_comb begin
      eff_w = (CXW'(grid_width_ff) > CXW'(MAX_COLS)) ? CXW'(MAX_COLS)
                                                     : CXW'(grid_width_ff);
      eff_h = (RXW'(grid_height_ff) > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS)
                                                      : RXW'(grid_height_ff);
      cx = CXW'(walker_col_ff);
      ry = RXW'(walker_row_ff);
      col_in_grid = cx < eff_w;
      row_in_grid = ry < eff_h;

      nb_cx[DIR_LEFT]  = cx - CXW'(1);
      nb_ry[DIR_LEFT]  = ry;
      nb_ok[DIR_LEFT]  = (cx != '0) && (nb_cx[DIR_LEFT] < eff_w) && row_in_grid;

      nb_cx[DIR_RIGHT] = cx + CXW'(1);
      nb_ry[DIR_RIGHT] = ry;
      nb_ok[DIR_RIGHT] = (nb_cx[DIR_RIGHT] < eff_w) && row_in_grid;

      nb_cx[DIR_UP]    = cx;
      nb_ry[DIR_UP]    = ry - RXW'(1);
      nb_ok[DIR_UP]    = (ry != '0) && (nb_ry[DIR_UP] < eff_h) && col_in_grid;

      nb_cx[DIR_DOWN]  = cx;
      nb_ry[DIR_DOWN]  = ry + RXW'(1);
      nb_ok[DIR_DOWN]  = (nb_ry[DIR_DOWN] < eff_h) && col_in_grid;

      for (int d = 0; d < 4; d++) begin
         nb_addr[d] = {nb_ry[d][RAW-1:0], nb_cx[d][CAW-1:0]};
      end
   end

   // ---------------------------------------------------------------- decide
   // Merge the map word returning this cycle into the seen mask.
   logic [3:0] seen_cur, free_dirs;
   logic [7:0] order_code;
   logic [1:0] try_dir, sel_dir;
   logic       found;

   always_comb begin
      seen_cur = seen_ff;
      if (rd_pend_ff) begin
         seen_cur[rd_dir_ff] = (vis_rdata == epoch_ff);
      end
      free_dirs  = nb_ok & ~seen_cur;
      order_code = ORDER_LUT[pick_ff];
      found      = 1'b0;
      sel_dir    = DIR_LEFT;
      try_dir    = DIR_LEFT;
      // first free neighbour in the picked try order
      for (int i = 0; i < 4; i++) begin
         try_dir = order_code[(3 - i) * 2 +: 2];
         if (!found && free_dirs[try_dir]) begin
            found   = 1'b1;
            sel_dir = try_dir;
         end
      end
   end

   // ---------------------------------------------------------------- control
   logic                out_free, take, start_bad, wrap;
   logic [PCW-1:0]      st_col, pop_col;
   logic [PRW-1:0]      st_row, pop_row;
   logic [VAW-1:0]      st_addr, wk_addr;
   logic                emit;
   logic [1:0]          emit_ev, emit_dir;
   logic [COORD_W-1:0]  emit_fc, emit_fr, emit_tc, emit_tr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign st_col    = PCW'(start_col_ff);
   assign st_row    = PRW'(start_row_ff);
   assign st_addr   = {st_row[RAW-1:0], st_col[CAW-1:0]};
   assign wk_addr   = {walker_row_ff[RAW-1:0], walker_col_ff[CAW-1:0]};
   assign start_bad = (CXW'(start_col_ff) >= eff_w) || (RXW'(start_row_ff) >= eff_h);
   assign wrap      = (epoch_ff == '1);
   assign pop_col   = PCW'(stk_rdata[CAW-1:0]);
   assign pop_row   = PRW'(stk_rdata[CAW +: RAW]);

   always_comb begin
      state_in      = state_ff;
      walker_col_in = walker_col_ff;
      walker_row_in = walker_row_ff;
      count_in      = count_ff;
      active_in     = active_ff;
      epoch_in      = epoch_ff;
      sweep_addr_in = sweep_addr_ff;
      pick_in       = pick_ff;
      rd_idx_in     = rd_idx_ff;
      rd_dir_in     = rd_dir_ff;
      rd_pend_in    = 1'b0;
      seen_in       = seen_cur;
      take          = 1'b0;

      vis_we    = 1'b0;
      vis_waddr = sweep_addr_ff;
      vis_wdata = '0;
      vis_re    = 1'b0;
      vis_raddr = nb_addr[DIR_LEFT];
      stk_we    = 1'b0;
      stk_waddr = count_ff[SAW-1:0];
      stk_wdata = wk_addr;
      stk_re    = 1'b0;
      stk_raddr = SAW'(count_ff - SCW'(1));

      emit     = 1'b0;
      emit_ev  = EV_IDLE;
      emit_dir = DIR_LEFT;
      emit_fc  = walker_col_ff[COORD_W-1:0];
      emit_fr  = walker_row_ff[COORD_W-1:0];
      emit_tc  = walker_col_ff[COORD_W-1:0];
      emit_tr  = walker_row_ff[COORD_W-1:0];

      case (state_ff)
         ST_SWEEP: begin
            // rewrite every map entry; keep the start cell of a walk already placed
            vis_we        = 1'b1;
            vis_waddr     = sweep_addr_ff;
            vis_wdata     = (active_ff && (sweep_addr_ff == wk_addr)) ? epoch_ff : '0;
            sweep_addr_in = sweep_addr_ff + VAW'(1);
            if (sweep_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (hold_valid_ff) begin
               if (hold_kind_ff == KIND_RESTART) begin
                  if (!start_bad || out_free) begin
                     take          = 1'b1;
                     count_in      = '0;
                     walker_col_in = st_col;
                     walker_row_in = st_row;
                     active_in     = !start_bad;
                     // new epoch clears the map; on wrap sweep it for real
                     epoch_in      = wrap ? MARK_W'(1) : epoch_ff + MARK_W'(1);
                     if (wrap) begin
                        state_in = ST_SWEEP;
                     end
                     if (!start_bad) begin
                        vis_we    = 1'b1;
                        vis_waddr = st_addr;
                        vis_wdata = epoch_in;
                     end else begin
                        emit    = 1'b1;
                        emit_ev = EV_IDLE;
                        emit_fc = start_col_ff;
                        emit_fr = start_row_ff;
                        emit_tc = start_col_ff;
                        emit_tr = start_row_ff;
                     end
                  end
               end else if (!active_ff) begin
                  if (out_free) begin
                     take    = 1'b1;
                     emit    = 1'b1;
                     emit_ev = EV_IDLE;
                  end
               end else begin
                  // start a step: first map read and the stack top read
                  take       = 1'b1;
                  pick_in    = hold_pick_ff;
                  vis_re     = 1'b1;
                  vis_raddr  = nb_addr[DIR_LEFT];
                  rd_pend_in = 1'b1;
                  rd_dir_in  = DIR_LEFT;
                  rd_idx_in  = DIR_RIGHT;
                  stk_re     = 1'b1;
                  state_in   = ST_READ;
               end
            end
         end

         ST_READ: begin
            vis_re     = 1'b1;
            vis_raddr  = nb_addr[rd_idx_ff];
            rd_pend_in = 1'b1;
            rd_dir_in  = rd_idx_ff;
            rd_idx_in  = rd_idx_ff + 2'd1;
            if (rd_idx_ff == DIR_DOWN) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (found) begin
                  if (count_ff < SCW'(CELLS)) begin
                     stk_we   = 1'b1;
                     count_in = count_ff + SCW'(1);
                  end
                  vis_we        = 1'b1;
                  vis_waddr     = nb_addr[sel_dir];
                  vis_wdata     = epoch_ff;
                  walker_col_in = PCW'(nb_cx[sel_dir]);
                  walker_row_in = PRW'(nb_ry[sel_dir]);
                  emit_ev       = EV_CARVE;
                  emit_dir      = sel_dir;
                  emit_tc       = nb_cx[sel_dir][COORD_W-1:0];
                  emit_tr       = nb_ry[sel_dir][COORD_W-1:0];
               end else if (count_ff != '0) begin
                  count_in      = count_ff - SCW'(1);
                  walker_col_in = pop_col;
                  walker_row_in = pop_row;
                  emit_ev       = EV_BACK;
                  emit_tc       = pop_col[COORD_W-1:0];
                  emit_tr       = pop_row[COORD_W-1:0];
               end else begin
                  emit_ev = EV_DONE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   assign req_stall = hold_valid_ff || (state_ff == ST_SWEEP);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_valid && !req_stall) begin
         hold_valid_in = 1'b1;
      end else if (take) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         grid_width_ff  <= GRID_W'(64);
         grid_height_ff <= GRID_W'(64);
         start_col_ff   <= '0;
         start_row_ff   <= '0;
         hold_valid_ff  <= 1'b0;
         walker_col_ff  <= '0;
         walker_row_ff  <= '0;
         count_ff       <= '0;
         active_ff      <= 1'b0;
         epoch_ff       <= '0;
         sweep_addr_ff  <= '0;
         rd_idx_ff      <= DIR_LEFT;
         rd_dir_ff      <= DIR_LEFT;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         start_col_ff   <= start_col_in;
         start_row_ff   <= start_row_in;
         hold_valid_ff  <= hold_valid_in;
         walker_col_ff  <= walker_col_in;
         walker_row_ff  <= walker_row_in;
         count_ff       <= count_in;
         active_ff      <= active_in;
         epoch_ff       <= epoch_in;
         sweep_addr_ff  <= sweep_addr_in;
         rd_idx_ff      <= rd_idx_in;
         rd_dir_ff      <= rd_dir_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hold_kind_ff <= req_kind;
         hold_pick_ff <= req_order_pick;
      end
      pick_ff <= pick_in;
      seen_ff <= seen_in;
      if (emit) begin
         rsp_event_ff    <= emit_ev;
         rsp_from_col_ff <= emit_fc;
         rsp_from_row_ff <= emit_fr;
         rsp_to_col_ff   <= emit_tc;
         rsp_to_row_ff   <= emit_tr;
         rsp_dir_ff      <= emit_dir;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_from_col  = rsp_from_col_ff;
   assign rsp_from_row  = rsp_from_row_ff;
   assign rsp_to_col    = rsp_to_col_ff;
   assign rsp_to_row    = rsp_to_row_ff;
   assign rsp_direction = rsp_dir_ff;

endmodule

/* rtl/core/mdfs_checker.sv */
// Port-level assertions for the maze walker and their bind to the top level.
module mdfs_checker
   import mdfs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_kind,
   input logic [PICK_W-1:0]   req_order_pick,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_event_res,
   input logic [COORD_W-1:0]  rsp_from_col,
   input logic [COORD_W-1:0]  rsp_from_row,
   input logic [COORD_W-1:0]  rsp_to_col,
   input logic [COORD_W-1:0]  rsp_to_row,
   input logic [1:0]          rsp_direction,
   input logic                psel,
   input logic                penable,
   input logic                pwrite,
   input logic [3:0]          paddr,
   input logic [31:0]         pwdata,
   input logic [31:0]         prdata,
   input logic                pready
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result beat is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // only a carve carries a direction
   a_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_CARVE) |-> (rsp_direction == DIR_LEFT))
      else $error("direction set on a non-carve result");

   // finished and not-started leave the walker in place
   a_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_res == EV_DONE) || (rsp_event_res == EV_IDLE))
      |-> (rsp_from_col == rsp_to_col) && (rsp_from_row == rsp_to_row))
      else $error("walker moved on finished or not-started result");

   // a carve moves along exactly one axis
   a_carve_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_CARVE)
      |-> ((rsp_to_col != rsp_from_col) != (rsp_to_row != rsp_from_row)))
      else $error("carve does not move along one axis");

endmodule

bind maze_dfs_backtracker mdfs_checker u_mdfs_checker (.*);
